### rtl/evi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased value interpolator package
// Shared widths, defaults, register indexes and curve codes for the tween
// unit and its serial multiplier.
// ----------------------------------------------------------------------------
package evi_pkg;

	// Default fixed-point format: signed 20.12 in 32 bits.
	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_FRAC_BITS   = 12;

	// Bits of the multiplier operand retired per cycle.
	localparam int DIGIT_BITS = 4;

	// Fixed field widths of the ports.
	localparam int COUNT_BITS     = 8;
	localparam int CURVE_BITS     = 2;
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 8;
	localparam int TARGET_BITS    = 32;
	localparam int RESULT_BITS    = 32;

	// Reset value of the transition length in ticks.
	localparam logic [COUNT_BITS-1:0] FRAMES_RESET = 8'd16;

	// First bounce segment: 121 * p * p / 16.
	localparam int BOUNCE_GAIN  = 121;
	localparam int BOUNCE_SHIFT = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_EASE_FRAMES  = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE_SELECT = 4'd1;

	// Curve selector codes; the unused code behaves as quadratic in-out.
	localparam logic [CURVE_BITS-1:0] CURVE_QUAD   = 2'd0;
	localparam logic [CURVE_BITS-1:0] CURVE_SMOOTH = 2'd1;
	localparam logic [CURVE_BITS-1:0] CURVE_BOUNCE = 2'd2;

endpackage

### rtl/evi_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Digit-serial fixed-point multiplier
// Multiplies two signed values one DIGIT_BITS digit of b per cycle and
// returns the product shifted right by FRAC_BITS, wrapped to VALUE_WIDTH.
// ----------------------------------------------------------------------------
module evi_mul #(
	parameter int VALUE_WIDTH = evi_pkg::DEF_VALUE_WIDTH,
	parameter int FRAC_BITS   = evi_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [VALUE_WIDTH-1:0] a,
	input  logic signed [VALUE_WIDTH-1:0] b,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] res
);
	import evi_pkg::*;

	// Only the low VALUE_WIDTH + FRAC_BITS product bits reach the result.
	localparam int PW   = VALUE_WIDTH + FRAC_BITS;
	localparam int NDIG = (VALUE_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int BW   = NDIG * DIGIT_BITS;
	localparam int CW   = $clog2(NDIG + 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CW-1:0]           cnt_q;
	logic signed [PW-1:0]    a_q;
	logic [BW-1:0]           b_q;
	logic [PW-1:0]           acc_q;
	logic                    last;
	logic signed [DIGIT_BITS:0]    dext;
	logic signed [PW+DIGIT_BITS:0] prod;

	// The top digit of b carries the sign; the others are unsigned.
	always_comb begin
		last = (cnt_q == CW'(1));
		if (last) begin
			dext = {b_q[DIGIT_BITS-1], b_q[DIGIT_BITS-1:0]};
		end else begin
			dext = {1'b0, b_q[DIGIT_BITS-1:0]};
		end
		prod = a_q * dext;
	end

	// Digit counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NDIG);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-add datapath: a moves up one digit, b down one digit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a);
			b_q   <= BW'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= a_q <<< DIGIT_BITS;
			b_q   <= b_q >> DIGIT_BITS;
			acc_q <= acc_q + prod[PW-1:0];
		end
	end

	assign done = done_q;
	assign res  = acc_q[FRAC_BITS +: VALUE_WIDTH];

endmodule

### rtl/eased_value_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased value interpolator
// Tween unit: keeps a start value, an end value and a frame counter and
// returns start + (end - start) * curve(frame / length) after every word.
// ----------------------------------------------------------------------------
// One word is taken at a time. The progress value, a fraction in the default
// 20.12 format, comes from a restoring divider that retires one quotient bit
// per cycle (skipped when the length is zero), and the curve then needs k
// passes through one shared 4-bit-digit serial multiplier, k being 2 for
// quadratic in-out and the first bounce segment, 3 for smoothstep and 4 for
// the other bounce segments. A set word whose target differs from the stored
// end value runs the evaluation twice, once to capture the new start value
// and once for the result. A finished result waits in an output register,
// so the next word is taken while it is still pending. The configuration
// port is always ready.
// ----------------------------------------------------------------------------
module eased_value_interpolator_top #(
	parameter int VALUE_WIDTH = evi_pkg::DEF_VALUE_WIDTH,
	parameter int FRAC_BITS   = evi_pkg::DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [evi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [evi_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [evi_pkg::TARGET_BITS-1:0]     s_tdata,  // [31:0] new_target
	input  logic                                s_tuser,  // [0] operation
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [evi_pkg::RESULT_BITS-1:0]     m_tdata   // [31:0] eased_value
);
	import evi_pkg::*;

	localparam int NUMW = COUNT_BITS + FRAC_BITS;
	localparam int DCW  = $clog2(NUMW + 1);

	// Curve constants, truncated to FRAC_BITS fraction bits.
	localparam logic [63:0] ONE_RAW = 64'd1 << FRAC_BITS;
	localparam logic signed [VALUE_WIDTH-1:0] K_ONE   = VALUE_WIDTH'(ONE_RAW);
	localparam logic signed [VALUE_WIDTH-1:0] K_HALF  = VALUE_WIDTH'(ONE_RAW / 64'd2);
	localparam logic signed [VALUE_WIDTH-1:0] K_THREE = VALUE_WIDTH'(64'd3 << FRAC_BITS);
	localparam logic signed [VALUE_WIDTH-1:0] K_ROUND =
		VALUE_WIDTH'((1 << BOUNCE_SHIFT) - 1);
	localparam logic signed [VALUE_WIDTH-1:0] K_B1 =
		VALUE_WIDTH'((64'd36363636363 << FRAC_BITS) / 64'd100000000000);
	localparam logic signed [VALUE_WIDTH-1:0] K_B2 =
		VALUE_WIDTH'((64'd72727272727 << FRAC_BITS) / 64'd100000000000);
	localparam logic signed [VALUE_WIDTH-1:0] K_B3 =
		VALUE_WIDTH'((64'd9 << FRAC_BITS) / 64'd10);
	localparam logic signed [VALUE_WIDTH-1:0] K_A2 =
		VALUE_WIDTH'((64'd9075 << FRAC_BITS) / 64'd1000);
	localparam logic signed [VALUE_WIDTH-1:0] K_L2 =
		VALUE_WIDTH'((64'd99 << FRAC_BITS) / 64'd10);
	localparam logic signed [VALUE_WIDTH-1:0] K_C2 =
		VALUE_WIDTH'((64'd34 << FRAC_BITS) / 64'd10);
	localparam logic signed [VALUE_WIDTH-1:0] K_A3 =
		VALUE_WIDTH'((64'd120664819945 << FRAC_BITS) / 64'd10000000000);
	localparam logic signed [VALUE_WIDTH-1:0] K_L3 =
		VALUE_WIDTH'((64'd196354570637 << FRAC_BITS) / 64'd10000000000);
	localparam logic signed [VALUE_WIDTH-1:0] K_C3 =
		VALUE_WIDTH'((64'd889806094183 << FRAC_BITS) / 64'd100000000000);
	localparam logic signed [VALUE_WIDTH-1:0] K_A4 =
		VALUE_WIDTH'((64'd108 << FRAC_BITS) / 64'd10);
	localparam logic signed [VALUE_WIDTH-1:0] K_L4 =
		VALUE_WIDTH'((64'd2052 << FRAC_BITS) / 64'd100);
	localparam logic signed [VALUE_WIDTH-1:0] K_C4 =
		VALUE_WIDTH'((64'd1072 << FRAC_BITS) / 64'd100);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_EVAL = 9'b000000010,
		ST_DIV  = 9'b000000100,
		ST_PSET = 9'b000001000,
		ST_MA   = 9'b000010000,
		ST_MB   = 9'b000100000,
		ST_MC   = 9'b001000000,
		ST_MF   = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// Configuration and tween state.
	logic [COUNT_BITS-1:0]         frames_q;
	logic [CURVE_BITS-1:0]         curve_q;
	logic [COUNT_BITS-1:0]         count_q;
	logic signed [VALUE_WIDTH-1:0] start_q;
	logic signed [VALUE_WIDTH-1:0] end_q;
	logic                          set_pend_q;
	logic signed [VALUE_WIDTH-1:0] tgt_q;

	// Working registers.
	logic signed [VALUE_WIDTH-1:0] p_q;
	logic signed [VALUE_WIDTH-1:0] x_q;
	logic signed [VALUE_WIDTH-1:0] v_q;
	logic [RESULT_BITS-1:0]        out_q;
	logic                          m_valid_q;

	// Divider.
	logic [NUMW-1:0]       num_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [DCW-1:0]        div_cnt_q;
	logic [COUNT_BITS:0]   rem_shift;
	logic [COUNT_BITS:0]   rem_diff;
	logic                  q_bit;
	logic                  div_last;

	// Curve datapath.
	logic                          is_smooth;
	logic                          is_bounce;
	logic                          p_lt_half;
	logic                          bounce_first;
	logic                          need_mb;
	logic signed [VALUE_WIDTH-1:0] p2;
	logic signed [VALUE_WIDTH-1:0] p4;
	logic signed [VALUE_WIDTH-1:0] p121;
	logic signed [VALUE_WIDTH-1:0] t3;
	logic signed [VALUE_WIDTH-1:0] coef_a;
	logic signed [VALUE_WIDTH-1:0] coef_b;
	logic signed [VALUE_WIDTH-1:0] coef_c;
	logic signed [VALUE_WIDTH-1:0] first_a;
	logic signed [VALUE_WIDTH-1:0] diff;
	logic signed [VALUE_WIDTH-1:0] quad_c;
	logic signed [VALUE_WIDTH-1:0] bsum;
	logic signed [VALUE_WIDTH-1:0] bq;
	logic signed [VALUE_WIDTH-1:0] poly_c;
	logic signed [VALUE_WIDTH-1:0] final_v;

	// Multiplier handshake.
	logic                          mul_start;
	logic                          mul_done;
	logic signed [VALUE_WIDTH-1:0] mul_a;
	logic signed [VALUE_WIDTH-1:0] mul_b;
	logic signed [VALUE_WIDTH-1:0] mul_res;

	logic in_acc;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = out_q;

	// One restoring divider step: shift in the next numerator bit.
	always_comb begin
		rem_shift = {rem_q, num_q[NUMW-1]};
		rem_diff  = rem_shift - {1'b0, frames_q};
		q_bit     = (rem_shift >= {1'b0, frames_q});
		div_last  = (div_cnt_q == DCW'(1));
	end

	// Curve selection and the bounce segment coefficients.
	always_comb begin
		case (curve_q)
			CURVE_SMOOTH: begin
				is_smooth = 1'b1;
				is_bounce = 1'b0;
			end
			CURVE_BOUNCE: begin
				is_smooth = 1'b0;
				is_bounce = 1'b1;
			end
			default: begin
				is_smooth = 1'b0;
				is_bounce = 1'b0;
			end
		endcase

		p_lt_half    = (p_q < K_HALF);
		bounce_first = (p_q < K_B1);
		need_mb      = is_smooth || (is_bounce && !bounce_first);

		if (p_q < K_B2) begin
			coef_a = K_A2;
			coef_b = K_L2;
			coef_c = K_C2;
		end else if (p_q < K_B3) begin
			coef_a = K_A3;
			coef_b = K_L3;
			coef_c = K_C3;
		end else begin
			coef_a = K_A4;
			coef_b = K_L4;
			coef_c = K_C4;
		end

		p2   = p_q <<< 1;
		p4   = p_q <<< 2;
		p121 = VALUE_WIDTH'(p_q * BOUNCE_GAIN);
		t3   = K_THREE - p2;
		diff = end_q - start_q;

		// First multiplier operand for each curve.
		if (is_smooth) begin
			first_a = p_q;
		end else if (is_bounce) begin
			first_a = bounce_first ? p121 : coef_a;
		end else begin
			first_a = p_lt_half ? p2 : -p2;
		end

		// Curve results that follow a multiplier pass.
		quad_c  = p_lt_half ? mul_res : mul_res + p4 - K_ONE;
		bsum    = mul_res[VALUE_WIDTH-1] ? mul_res + K_ROUND : mul_res;
		bq      = bsum >>> BOUNCE_SHIFT;
		poly_c  = x_q - mul_res + coef_c;
		final_v = start_q + mul_res;
	end

	// Sequencer: next state and multiplier operand selection.
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = p_q;
		mul_b     = p_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = (frames_q == '0) ? ST_PSET : ST_DIV;
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_PSET;
				end
			end
			ST_PSET: begin
				mul_start = 1'b1;
				mul_a     = first_a;
				state_d   = ST_MA;
			end
			ST_MA: begin
				if (mul_done) begin
					mul_start = 1'b1;
					if (need_mb) begin
						mul_a   = mul_res;
						mul_b   = is_smooth ? t3 : p_q;
						state_d = ST_MB;
					end else begin
						mul_a   = diff;
						mul_b   = is_bounce ? bq : quad_c;
						state_d = ST_MF;
					end
				end
			end
			ST_MB: begin
				if (mul_done) begin
					mul_start = 1'b1;
					if (is_smooth) begin
						mul_a   = diff;
						mul_b   = mul_res;
						state_d = ST_MF;
					end else begin
						mul_a   = coef_b;
						state_d = ST_MC;
					end
				end
			end
			ST_MC: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = diff;
					mul_b     = poly_c;
					state_d   = ST_MF;
				end
			end
			ST_MF: begin
				if (mul_done) begin
					state_d = set_pend_q ? ST_EVAL : ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and tween state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			frames_q   <= FRAMES_RESET;
			curve_q    <= CURVE_QUAD;
			count_q    <= '0;
			start_q    <= '0;
			end_q      <= '0;
			set_pend_q <= 1'b0;
			m_valid_q  <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			state_q <= state_d;

			// Register writes; unknown indexes are dropped.
			if (cfg_valid) begin
				case (cfg_index)
					REG_EASE_FRAMES:  frames_q <= cfg_data[COUNT_BITS-1:0];
					REG_CURVE_SELECT: curve_q  <= cfg_data[CURVE_BITS-1:0];
					default: ;
				endcase
			end

			// A tick advances the counter up to the length; a set word that
			// moves the end point schedules a start-value capture.
			if (in_acc) begin
				set_pend_q <= s_tuser && (VALUE_WIDTH'(s_tdata) != end_q);
				if (!s_tuser && (count_q < frames_q)) begin
					count_q <= count_q + COUNT_BITS'(1);
				end
			end

			if (state_q == ST_EVAL) begin
				div_cnt_q <= DCW'(NUMW);
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end

			// Capture the current value as the new start and rerun.
			if ((state_q == ST_MF) && mul_done && set_pend_q) begin
				start_q    <= final_v;
				end_q      <= tgt_q;
				count_q    <= '0;
				set_pend_q <= 1'b0;
			end

			// Output register: loads when empty or being drained.
			if ((state_q == ST_OUT) && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tgt_q <= VALUE_WIDTH'(s_tdata);
		end

		case (state_q)
			ST_EVAL: begin
				num_q <= {count_q, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				if (frames_q == '0) begin
					p_q <= K_ONE;
				end
			end
			ST_DIV: begin
				num_q <= {num_q[NUMW-2:0], q_bit};
				rem_q <= q_bit ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
				if (div_last) begin
					p_q <= VALUE_WIDTH'({num_q[NUMW-2:0], q_bit});
				end
			end
			ST_MB: begin
				if (mul_done) begin
					x_q <= mul_res;
				end
			end
			ST_MF: begin
				if (mul_done) begin
					v_q <= final_v;
				end
			end
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					out_q <= RESULT_BITS'(v_q);
				end
			end
			default: ;
		endcase
	end

	// Shared serial multiplier.
	evi_mul #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.res   (mul_res)
	);

endmodule

### rtl/evi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased value interpolator port checker
// Watches the stream ports of the tween unit and checks that results pair up
// with accepted words.
// ----------------------------------------------------------------------------
module evi_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [evi_pkg::RESULT_BITS-1:0]   m_tdata
);
	logic       s_acc;
	logic       m_acc;
	logic [1:0] pend_q;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// Words accepted whose result has not been taken yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, s_acc} - {1'b0, m_acc};
		end
	end

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// No result appears without an accepted word behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result without an accepted word");

	// At most one word in work plus one result waiting.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !s_tready)
		else $error("input taken with a result and a word already pending");

	// A result never shows in the cycle right after its word is taken.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && pend_q == 2'd0 |=> !m_tvalid)
		else $error("result too early");

endmodule

bind eased_value_interpolator_top evi_checker u_evi_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased value interpolator testbench
// Drives tick and set words through the stream port, predicts every eased
// value with a local fixed-point model and checks each output word in order.
// Configuration sweeps the transition length and every curve code.
// ----------------------------------------------------------------------------
module tb;

	import evi_pkg::*;

	localparam int FB = DEF_FRAC_BITS;

	// Operation carried in tuser.
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	// Selector code that has no curve of its own.
	localparam logic [CURVE_BITS-1:0] CURVE_SPARE = 2'd3;

	// Register indexes that map to no register.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LAST  = 4'd15;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [TARGET_BITS-1:0]    s_tdata = '0;  // [31:0] new_target
	logic                      s_tuser = 1'b0;  // [0] operation
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [RESULT_BITS-1:0]    m_tdata;  // [31:0] eased_value

	// Local copy of the tween state and its configuration.
	longint                  model_start;
	longint                  model_end;
	logic [COUNT_BITS-1:0]   model_frames;
	logic [COUNT_BITS-1:0]   cfg_length;
	logic [CURVE_BITS-1:0]   cfg_curve;

	logic [RESULT_BITS-1:0]  expected_values[$];
	logic [RESULT_BITS-1:0]  want_value;

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_cycles = 0;
	int failures = 0;
	int words_sent = 0;
	int results_checked = 0;
	int cfg_writes = 0;

	eased_value_interpolator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	// Run time guard.
	initial begin
		#3_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Fixed-point predictor
	// ------------------------------------------------------------------

	// Wrap to the 32-bit two's complement value range.
	function automatic longint wrap32(input longint x);
		int t;
		t = int'(x);
		return longint'(t);
	endfunction

	// Fixed-point product, floored and wrapped.
	function automatic longint fxmul(input longint a, input longint b);
		return wrap32((a * b) >>> FB);
	endfunction

	// Integer-by-fixed product.
	function automatic longint ixmul(input longint k, input longint a);
		return wrap32(k * a);
	endfunction

	// Curve constant num/den truncated to the fraction bits.
	function automatic longint kconst(input longint unsigned num, input longint unsigned den);
		return wrap32(longint'((num << FB) / den));
	endfunction

	function automatic longint ease_quad(input longint p);
		if (p < kconst(1, 2)) begin
			return fxmul(ixmul(2, p), p);
		end
		return wrap32(wrap32(fxmul(ixmul(-2, p), p) + ixmul(4, p)) - kconst(1, 1));
	endfunction

	function automatic longint ease_smooth(input longint p);
		longint t;
		t = wrap32(kconst(3, 1) - ixmul(2, p));
		return fxmul(fxmul(p, p), t);
	endfunction

	// One parabolic bounce segment: a*p*p - b*p + c.
	function automatic longint bounce_seg(input longint a, input longint b, input longint c,
			input longint p);
		return wrap32(wrap32(fxmul(fxmul(a, p), p) - fxmul(b, p)) + c);
	endfunction

	function automatic longint ease_bounce(input longint p);
		if (p < kconst(64'd36363636363, 64'd100000000000)) begin
			// Signed division truncates toward zero here.
			return fxmul(ixmul(BOUNCE_GAIN, p), p) / (64'sd1 << BOUNCE_SHIFT);
		end
		if (p < kconst(64'd72727272727, 64'd100000000000)) begin
			return bounce_seg(kconst(9075, 1000), kconst(99, 10), kconst(34, 10), p);
		end
		if (p < kconst(9, 10)) begin
			return bounce_seg(kconst(64'd120664819945, 64'd10000000000),
				kconst(64'd196354570637, 64'd10000000000),
				kconst(64'd889806094183, 64'd100000000000), p);
		end
		return bounce_seg(kconst(108, 10), kconst(2052, 100), kconst(1072, 100), p);
	endfunction

	// Eased value for the current state and configuration.
	function automatic longint eased_now();
		longint p;
		longint c;
		if (cfg_length == 0) begin
			p = kconst(1, 1);
		end else begin
			p = wrap32((longint'(model_frames) << FB) / longint'(cfg_length));
		end
		if (cfg_curve == CURVE_SMOOTH) begin
			c = ease_smooth(p);
		end else if (cfg_curve == CURVE_BOUNCE) begin
			c = ease_bounce(p);
		end else begin
			c = ease_quad(p);
		end
		return wrap32(model_start + fxmul(wrap32(model_end - model_start), c));
	endfunction

	// Apply one accepted word to the model and queue the eased value it yields.
	function automatic void advance_tween(input op_t op, input logic [31:0] target);
		longint tgt;
		longint eased;
		if (op == OP_SET) begin
			tgt = longint'($signed(target));
			if (tgt != model_end) begin
				model_start = eased_now();
				model_end = tgt;
				model_frames = '0;
			end
		end else if (model_frames < cfg_length) begin
			model_frames = model_frames + 1'b1;
		end
		eased = eased_now();
		expected_values.push_back(eased[31:0]);
	endfunction

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// Receiver readiness: a long hold-off when requested, else random idling.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready = 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_tready = ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Compare every output word with the oldest expected eased value.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_values.size() == 0) begin
				$error("eased_value: no word expected, got %h", m_tdata);
				failures++;
			end else begin
				want_value = expected_values.pop_front();
				if (m_tdata !== want_value) begin
					$error("eased_value: expected %h, actual %h", want_value, m_tdata);
					failures++;
				end
				results_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one word, idling first at random, and wait for acceptance.
	task automatic send_word(input op_t op, input logic [31:0] target);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = target;
		do @(posedge clk); while (!s_tready);
		advance_tween(op, target);
		words_sent++;
	endtask

	// Stop offering and wait until every expected word has arrived.
	task automatic wait_drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (expected_values.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	// Write one configuration register while the block is idle.
	task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		wait_drain();
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (index == REG_EASE_FRAMES) begin
			cfg_length = data;
		end else if (index == REG_CURVE_SELECT) begin
			cfg_curve = data[CURVE_BITS-1:0];
		end
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Target values: full range, small, extremes and scaled.
	function automatic logic [31:0] random_target();
		logic [31:0] r;
		case ($urandom_range(3))
			0: r = $urandom();
			1: r = $urandom_range(131072) - 65536;
			2: begin
				case ($urandom_range(3))
					0: r = 32'h7FFF_FFFF;
					1: r = 32'h8000_0000;
					2: r = 32'h0000_0000;
					default: r = 32'hFFFF_FFFF;
				endcase
			end
			default: r = $signed($urandom()) >>> $urandom_range(31);
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Extreme targets, both operations and an unchanged target at reset settings.
	task automatic test_directed_words();
		send_word(OP_TICK, 32'h0000_0000);
		send_word(OP_SET, 32'h7FFF_FFFF);
		send_word(OP_TICK, 32'h0000_0000);
		send_word(OP_TICK, 32'h5555_5555);
		send_word(OP_SET, 32'h7FFF_FFFF);
		send_word(OP_SET, 32'h8000_0000);
		send_word(OP_TICK, 32'hAAAA_AAAA);
		send_word(OP_SET, 32'h0000_0000);
		send_word(OP_SET, 32'hFFFF_FFFF);
		send_word(OP_TICK, 32'hFFFF_FFFF);
	endtask

	// Zero length, counter beyond length, the spare selector, unknown indexes.
	task automatic test_config_corners();
		cfg_write(REG_EASE_FRAMES, 8'd0);
		send_word(OP_TICK, 32'h0);
		send_word(OP_SET, 32'h0010_0000);
		send_word(OP_TICK, 32'h0);
		cfg_write(REG_EASE_FRAMES, 8'd3);
		cfg_write(REG_CURVE_SELECT, {6'b0, CURVE_SMOOTH});
		send_word(OP_SET, 32'h8000_0000);
		repeat (4) send_word(OP_TICK, 32'h0);
		// Shorter than the counter: progress goes past one and holds.
		cfg_write(REG_EASE_FRAMES, 8'd1);
		send_word(OP_TICK, 32'h0);
		cfg_write(REG_CURVE_SELECT, {6'b111111, CURVE_BOUNCE});
		send_word(OP_TICK, 32'h0);
		cfg_write(REG_CURVE_SELECT, {6'b0, CURVE_SPARE});
		send_word(OP_TICK, 32'h0);
		// Writes to unused indexes leave every register alone.
		cfg_write(REG_SPARE_FIRST, 8'hFF);
		cfg_write(REG_SPARE_LAST, 8'h00);
		send_word(OP_TICK, 32'h0);
		send_word(OP_SET, 32'h0123_4567);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_output_backpressure();
		cfg_write(REG_EASE_FRAMES, 8'd8);
		cfg_write(REG_CURVE_SELECT, {6'b0, CURVE_QUAD});
		src_idle_pct = 0;
		@(posedge clk);
		hold_cycles = 400;
		repeat (12) begin
			send_word(($urandom_range(1) != 0) ? OP_SET : OP_TICK, random_target());
		end
	endtask

	// Random transitions over several settings; mostly a target followed by ticks.
	task automatic test_random_tweens(input int src_pct, input int sink_pct, input int budget);
		int per;
		int sent;
		int len;
		int ticks;
		int roll;
		logic [CURVE_BITS-1:0] curve;
		per = budget / 6;
		for (int s = 0; s < 6; s++) begin
			case (s)
				0: len = 1;
				1: len = 255;
				2: len = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 24);
				default: len = $urandom_range(2, 24);
			endcase
			curve = (s < 4) ? CURVE_BITS'(s) : CURVE_BITS'($urandom_range(3));
			src_idle_pct = src_pct;
			sink_idle_pct = sink_pct;
			cfg_write(REG_EASE_FRAMES, CFG_DATA_BITS'(len));
			cfg_write(REG_CURVE_SELECT, {6'($urandom()), curve});
			sent = 0;
			while (sent < per) begin
				roll = $urandom_range(99);
				if (roll < 75) begin
					send_word(OP_SET, random_target());
					sent++;
					ticks = $urandom_range(0, ((len > 40) ? 40 : len) + 2);
					repeat (ticks) begin
						send_word(OP_TICK, $urandom());
						sent++;
					end
				end else if (roll < 85) begin
					// Same target as stored: no new transition starts.
					send_word(OP_SET, model_end[31:0]);
					sent++;
				end else begin
					send_word(($urandom_range(1) != 0) ? OP_SET : OP_TICK, random_target());
					sent++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_length = FRAMES_RESET;
		cfg_curve = CURVE_QUAD;
		model_start = 0;
		model_end = 0;
		model_frames = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		src_idle_pct = 24;
		sink_idle_pct = 59;
		test_directed_words();
		test_config_corners();
		test_random_tweens(24, 59, 280);
		test_random_tweens(59, 24, 280);
		test_output_backpressure();
		test_random_tweens(0, 0, 280);

		wait_drain();
		repeat (150) @(posedge clk);
		if (expected_values.size() != 0) begin
			$error("eased_value: %0d expected words never arrived", expected_values.size());
			failures++;
		end
		$display("tb: %0d words sent, %0d eased values checked, %0d register writes",
			words_sent, results_checked, cfg_writes);
		$display("tb: lengths 0 to 255, all curve codes, idling and a long output stall");
		if (failures == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
